// File: hw/rtl/bsnh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsnh_pkg
// constants, noise table and bit-swap permutations for the byte stream hash
// ----------------------------------------------------------------------------
package bsnh_pkg;

	localparam int unsigned HASH_W   = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned IDX_W    = 5;
	localparam int unsigned SEL_W    = 2;
	localparam int unsigned N_PAIRS  = 16;

	localparam logic [HASH_W-1:0] HASH_RESET_INIT = 32'hAC3B843B;
	localparam logic [15:0]       BYTE_MUL        = 16'd238;
	localparam logic [HASH_W-1:0] ROT_ADD         = 32'd1057592071;

	typedef logic [HASH_W-1:0] hash_t;
	typedef logic [BYTE_W-1:0] byte_t;

	localparam hash_t NOISE_WORDS [32] = '{
		32'h347cf746, 32'h7b840e02, 32'h4b6e3c4e, 32'h489b06c6,
		32'h2ba14c6e, 32'h4572434a, 32'h04600530, 32'h7f9acc78,
		32'h50a98955, 32'h071b0827, 32'h15690047, 32'h6c68f552,
		32'h5fc52edf, 32'h61ca273b, 32'h44e4c5f4, 32'h6a8f5fc5,
		32'h01fc910a, 32'h29e9de3f, 32'h2788c41e, 32'h6b5c5ce4,
		32'h39d672de, 32'h6d7680bf, 32'h511f385d, 32'h577fa18f,
		32'h7aa4ca0d, 32'h671710ed, 32'h127e0c78, 32'h567cb335,
		32'h65f0a296, 32'h3f0eaf85, 32'h4e838e1f, 32'h1a6d99dd
	};

	localparam logic [4:0] SWAP_PAIRS [4][16][2] = '{
		'{ '{5'd23,5'd16}, '{5'd25,5'd13}, '{5'd15,5'd10}, '{5'd6,5'd19},
		   '{5'd3,5'd2},   '{5'd11,5'd14}, '{5'd4,5'd24},  '{5'd20,5'd18},
		   '{5'd7,5'd30},  '{5'd0,5'd29},  '{5'd9,5'd28},  '{5'd1,5'd17},
		   '{5'd12,5'd27}, '{5'd26,5'd21}, '{5'd31,5'd8},  '{5'd22,5'd5} },
		'{ '{5'd7,5'd19},  '{5'd30,5'd6},  '{5'd20,5'd15}, '{5'd21,5'd8},
		   '{5'd24,5'd12}, '{5'd9,5'd14},  '{5'd0,5'd25},  '{5'd1,5'd17},
		   '{5'd26,5'd4},  '{5'd31,5'd23}, '{5'd27,5'd29}, '{5'd18,5'd10},
		   '{5'd2,5'd16},  '{5'd28,5'd13}, '{5'd11,5'd22}, '{5'd5,5'd3} },
		'{ '{5'd28,5'd30}, '{5'd10,5'd31}, '{5'd4,5'd26},  '{5'd19,5'd8},
		   '{5'd5,5'd0},   '{5'd18,5'd11}, '{5'd15,5'd22}, '{5'd14,5'd1},
		   '{5'd17,5'd23}, '{5'd16,5'd29}, '{5'd27,5'd7},  '{5'd9,5'd12},
		   '{5'd2,5'd25},  '{5'd20,5'd24}, '{5'd21,5'd13}, '{5'd3,5'd6} },
		'{ '{5'd17,5'd22}, '{5'd20,5'd16}, '{5'd10,5'd12}, '{5'd24,5'd23},
		   '{5'd21,5'd5},  '{5'd19,5'd27}, '{5'd18,5'd15}, '{5'd14,5'd8},
		   '{5'd0,5'd28},  '{5'd2,5'd4},   '{5'd1,5'd25},  '{5'd29,5'd6},
		   '{5'd26,5'd31}, '{5'd13,5'd30}, '{5'd9,5'd11},  '{5'd3,5'd7} }
	};

	function automatic hash_t permute(input hash_t x, input logic [SEL_W-1:0] sel);
		hash_t      r;
		logic [4:0] a;
		logic [4:0] b;
		r = '0;
		for (int k = 0; k < N_PAIRS; k++) begin
			a = SWAP_PAIRS[sel][k][0];
			b = SWAP_PAIRS[sel][k][1];
			r[b] = x[a];
			r[a] = x[b];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/byte_stream_noise_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_noise_hash_core
// 32-bit running hash over a byte stream, emitted on the last byte
// ----------------------------------------------------------------------------
// The core takes one byte per clock cycle and sustains that rate indefinitely
// as long as results are taken. Each byte is held in the input stage,
// where the whole update (two noise adds and a noise xor) is applied to the
// running hash; the hash of a message is loaded into the result register as
// its last byte leaves the input stage, which raises out_valid. The clock
// rate is set by the update loop through the running hash register: two
// chained add, table subtract and permute steps. A stalled result holds back
// the input only when another last byte is waiting behind it. initial_value
// is sampled at each first byte; write it between messages.
module byte_stream_noise_hash_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            initial_value_we,
	input  bsnh_pkg::hash_t initial_value,
	input  logic            in_valid,
	output logic            in_ready,
	input  bsnh_pkg::byte_t data_byte,
	input  logic            first_byte,
	input  logic            last_byte,
	output logic            out_valid,
	input  logic            out_ready,
	output bsnh_pkg::hash_t hash_value
);

	bsnh_pkg::hash_t initial_value_q;
	bsnh_pkg::hash_t running_hash_q;
	bsnh_pkg::hash_t hash_q;
	bsnh_pkg::hash_t h_start;
	bsnh_pkg::hash_t h_next;
	bsnh_pkg::byte_t data_s1;
	logic            first_s1;
	logic            last_s1;
	logic            valid_s1;
	logic            out_valid_q;
	logic            out_free;
	logic            adv_s1;

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv_s1;
	assign h_start  = first_s1 ? initial_value_q : running_hash_q;

	bsnh_round u_round (.h_in(h_start), .data(data_s1), .h_out(h_next));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_value_q <= bsnh_pkg::HASH_RESET_INIT;
			running_hash_q  <= bsnh_pkg::HASH_RESET_INIT;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (initial_value_we) begin
				initial_value_q <= initial_value;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				running_hash_q <= h_next;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
		if (adv_s1 && last_s1) begin
			hash_q <= h_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	// input stalls only behind a waiting result with another last byte queued
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && last_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a blocked last byte");

	// a new result only comes from a last byte leaving the input stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(adv_s1 && last_s1))
		else $error("result raised without a last byte");

	// emitted hash matches the running hash it was taken from
	a_result_value: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (out_valid_q && hash_q == running_hash_q))
		else $error("result differs from running hash");

	// running hash only moves when a byte is processed
	a_hash_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(running_hash_q))
		else $error("running hash changed without a byte");

endmodule

// File: hw/rtl/bsnh_noise.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsnh_noise
// table subtract followed by one of four fixed bit-swap permutations
// ----------------------------------------------------------------------------
module bsnh_noise (
	input  bsnh_pkg::hash_t x,
	output bsnh_pkg::hash_t y
);

	bsnh_pkg::hash_t diff;

	assign diff = x - bsnh_pkg::NOISE_WORDS[x[bsnh_pkg::IDX_W-1:0]];
	assign y    = bsnh_pkg::permute(diff, x[bsnh_pkg::SEL_W-1:0]);

endmodule

// File: hw/rtl/bsnh_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsnh_round
// one byte update of the running hash: two noise adds and one noise xor
// ----------------------------------------------------------------------------
module bsnh_round (
	input  bsnh_pkg::hash_t h_in,
	input  bsnh_pkg::byte_t data,
	output bsnh_pkg::hash_t h_out
);

	bsnh_pkg::hash_t arg1;
	bsnh_pkg::hash_t arg2;
	bsnh_pkg::hash_t arg3;
	bsnh_pkg::hash_t rot_src;
	bsnh_pkg::hash_t n1;
	bsnh_pkg::hash_t n2;
	bsnh_pkg::hash_t n3;
	bsnh_pkg::hash_t h1;
	bsnh_pkg::hash_t h2;
	logic [15:0]     prod;

	assign prod    = {8'd0, data} * bsnh_pkg::BYTE_MUL;
	assign arg1    = h_in + {28'd0, data[7:4]};
	assign h1      = h_in + n1;
	assign arg2    = h1 + {16'd0, prod};
	assign h2      = h1 + n2;
	assign rot_src = bsnh_pkg::ROT_ADD + {24'd0, data};
	// rotate right by 15
	assign arg3    = {rot_src[14:0], rot_src[31:15]};
	assign h_out   = h2 ^ n3;

	bsnh_noise u_noise1 (.x(arg1), .y(n1));
	bsnh_noise u_noise2 (.x(arg2), .y(n2));
	bsnh_noise u_noise3 (.x(arg3), .y(n3));

endmodule

// File: dv/byte_stream_noise_hash_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_noise_hash_core_test
// self-checking bench for the byte stream noise hash core
// ----------------------------------------------------------------------------
// Drives messages byte by byte through the valid/ready input channel, with
// random gaps and random result stalls (one phase has neither). A predictor
// in the bench recomputes the running hash on every accepted byte and queues
// the hash of each message's last byte. Every transaction on the result side
// is compared with the oldest queued hash. The start value register is
// rewritten between phases, only once the core has drained.
// ----------------------------------------------------------------------------
module byte_stream_noise_hash_core_test;

	typedef bsnh_pkg::hash_t hash_t;
	typedef bsnh_pkg::byte_t byte_t;

	localparam hash_t START_AT_RESET = 32'hAC3B843B;
	localparam hash_t BYTE_SCALE     = 32'd238;
	localparam hash_t ROT_OFFSET     = 32'd1057592071;
	localparam int    DRAIN_CYCLES   = 4;
	localparam int    IDLE_PCT       = 31;

	localparam hash_t MIX_WORDS [32] = '{
		32'h347cf746, 32'h7b840e02, 32'h4b6e3c4e, 32'h489b06c6,
		32'h2ba14c6e, 32'h4572434a, 32'h04600530, 32'h7f9acc78,
		32'h50a98955, 32'h071b0827, 32'h15690047, 32'h6c68f552,
		32'h5fc52edf, 32'h61ca273b, 32'h44e4c5f4, 32'h6a8f5fc5,
		32'h01fc910a, 32'h29e9de3f, 32'h2788c41e, 32'h6b5c5ce4,
		32'h39d672de, 32'h6d7680bf, 32'h511f385d, 32'h577fa18f,
		32'h7aa4ca0d, 32'h671710ed, 32'h127e0c78, 32'h567cb335,
		32'h65f0a296, 32'h3f0eaf85, 32'h4e838e1f, 32'h1a6d99dd
	};

	// bit positions exchanged in pairs, one row per permutation
	localparam int unsigned BIT_PAIRS [4][32] = '{
		'{23,16, 25,13, 15,10, 6,19, 3,2, 11,14, 4,24, 20,18,
		  7,30, 0,29, 9,28, 1,17, 12,27, 26,21, 31,8, 22,5},
		'{7,19, 30,6, 20,15, 21,8, 24,12, 9,14, 0,25, 1,17,
		  26,4, 31,23, 27,29, 18,10, 2,16, 28,13, 11,22, 5,3},
		'{28,30, 10,31, 4,26, 19,8, 5,0, 18,11, 15,22, 14,1,
		  17,23, 16,29, 27,7, 9,12, 2,25, 20,24, 21,13, 3,6},
		'{17,22, 20,16, 10,12, 24,23, 21,5, 19,27, 18,15, 14,8,
		  0,28, 2,4, 1,25, 29,6, 26,31, 13,30, 9,11, 3,7}
	};

	typedef struct packed {
		byte_t data;
		logic  first;
		logic  last;
	} msg_byte_t;

	logic  clk              = 1'b0;
	logic  arst_n           = 1'b0;
	logic  initial_value_we = 1'b0;
	hash_t initial_value    = '0;
	logic  in_valid         = 1'b0;
	logic  in_ready;
	byte_t data_byte        = '0;
	logic  first_byte       = 1'b0;
	logic  last_byte        = 1'b0;
	logic  out_valid;
	logic  out_ready        = 1'b0;
	hash_t hash_value;

	msg_byte_t byte_queue [$];
	hash_t     expected_hashes [$];
	hash_t     start_value     = START_AT_RESET;
	hash_t     chain_hash      = START_AT_RESET;
	logic      byte_taken      = 1'b0;
	int        idle_pct        = IDLE_PCT;
	int        mismatch_count  = 0;

	byte_stream_noise_hash_core uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.initial_value_we (initial_value_we),
		.initial_value    (initial_value),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.first_byte       (first_byte),
		.last_byte        (last_byte),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.hash_value       (hash_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic hash_t swap_bits(input hash_t x, input logic [1:0] sel);
		hash_t       r;
		int unsigned a;
		int unsigned b;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			a = BIT_PAIRS[sel][2*k];
			b = BIT_PAIRS[sel][2*k+1];
			r[a] = x[b];
			r[b] = x[a];
		end
		return r;
	endfunction

	function automatic hash_t noise_mix(input hash_t x);
		return swap_bits(x - MIX_WORDS[x[4:0]], x[1:0]);
	endfunction

	function automatic hash_t hash_byte(input hash_t h, input byte_t b);
		hash_t t;
		hash_t w;
		t = h + noise_mix(h + hash_t'(b[7:4]));
		t = t + noise_mix(t + hash_t'(b) * BYTE_SCALE);
		w = ROT_OFFSET + hash_t'(b);
		t = t ^ noise_mix({w[14:0], w[31:15]});
		return t;
	endfunction

	task automatic report_mismatch(input string what, input hash_t got, input hash_t want);
		$display("%0t ns: %s: got %08h, expected %08h", $time, what, got, want);
		mismatch_count++;
	endtask

	// driver, on each falling edge: a new byte or a gap once the previous byte is taken, and a new out_ready
	always @(negedge clk) begin : driver
		msg_byte_t it;
		if (arst_n) begin
			if (!in_valid || byte_taken) begin
				if (byte_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					it = byte_queue.pop_front();
					in_valid   <= 1'b1;
					data_byte  <= it.data;
					first_byte <= it.first;
					last_byte  <= it.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// monitor: predicts on input transactions, checks output transactions
	always @(posedge clk) begin : monitor
		hash_t h;
		hash_t want;
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			byte_taken <= in_valid && in_ready;
			if (initial_value_we) begin
				start_value <= initial_value;
			end
			if (out_valid && out_ready) begin
				if (expected_hashes.size() == 0) begin
					report_mismatch("unexpected hash", hash_value, 'x);
				end else begin
					want = expected_hashes.pop_front();
					if (hash_value !== want) begin
						report_mismatch("hash_value", hash_value, want);
					end
				end
			end
			if (in_valid && in_ready) begin
				h = hash_byte(first_byte ? start_value : chain_hash, data_byte);
				chain_hash <= h;
				if (last_byte) begin
					expected_hashes.push_back(h);
				end
			end
		end
	end

	task automatic add_byte(input byte_t d, input logic f, input logic l);
		byte_queue.push_back('{data: d, first: f, last: l});
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (byte_queue.size() != 0 || in_valid || expected_hashes.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_value(input hash_t v);
		@(negedge clk);
		initial_value_we <= 1'b1;
		initial_value    <= v;
		@(negedge clk);
		initial_value_we <= 1'b0;
	endtask

	function automatic byte_t pick_byte();
		case ($urandom_range(0, 9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_random_messages(input int count);
		int n;
		int len;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 99) < 15) begin
				add_byte(pick_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				n++;
			end else begin
				len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 48)
				                                     : $urandom_range(1, 10);
				for (int i = 0; i < len; i++) begin
					add_byte(pick_byte(), i == 0, i == len - 1);
				end
				n += len;
			end
		end
	endtask

	initial begin : stimulus
		hash_t phase_values [8];
		phase_values = '{32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
		                 32'h7FFF_FFFF, 32'hA5A5_5A5A, 32'h0, 32'h0};
		phase_values[6] = hash_t'($urandom);
		phase_values[7] = hash_t'($urandom);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset start value, continuation without a first byte
		add_byte(8'h00, 1'b0, 1'b1);
		add_byte(8'hFF, 1'b1, 1'b1);
		add_byte(8'h00, 1'b1, 1'b0);
		add_byte(8'hFF, 1'b0, 1'b0);
		add_byte(8'hAA, 1'b0, 1'b0);
		add_byte(8'h55, 1'b0, 1'b1);
		add_byte(8'h01, 1'b0, 1'b1);
		add_byte(8'h80, 1'b1, 1'b0);
		wait_drained();

		// written mid-message: old start value still applies to this message
		write_start_value(32'h0000_0000);
		add_byte(8'h7F, 1'b0, 1'b1);
		add_byte(8'h00, 1'b1, 1'b1);
		add_byte(8'hFF, 1'b1, 1'b0);
		add_byte(8'hFF, 1'b0, 1'b1);
		wait_drained();

		write_start_value(32'hFFFF_FFFF);
		add_byte(8'h00, 1'b1, 1'b1);
		add_byte(8'hFF, 1'b1, 1'b1);
		add_byte(8'h12, 1'b1, 1'b0);
		add_byte(8'h34, 1'b0, 1'b0);
		add_byte(8'h56, 1'b0, 1'b1);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			write_start_value(phase_values[p]);
			idle_pct = (p == 3) ? 0 : IDLE_PCT;
			add_random_messages(165);
			wait_drained();
		end

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/bsnh_pkg.sv
hw/rtl/bsnh_noise.sv
hw/rtl/bsnh_round.sv
hw/rtl/byte_stream_noise_hash_core.sv
dv/byte_stream_noise_hash_core_test.sv
